// ===== design/gyro_bias_calibrate_integrate_assert.svh =====
// assertion macros for the gyro bias calibrate and integrate block
// expects clk and arst_n in the scope of each use
`ifndef GYRO_BIAS_CALIBRATE_INTEGRATE_ASSERT_SVH
`define GYRO_BIAS_CALIBRATE_INTEGRATE_ASSERT_SVH

// condition must hold at every edge outside reset
`define GBCI_ASSERT_ALWAYS(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// consequent must hold at any edge where the antecedent holds
`define GBCI_ASSERT_IMPLIES(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

`endif

// ===== design/gbci_pkg.sv =====
// shared types and constants for the gyro bias calibrate and integrate block
// no dependencies
package gbci_pkg;

	localparam int SAMPLE_BITS = 16;
	localparam int COUNT_BITS  = 24;
	localparam int SUM_BITS    = SAMPLE_BITS + COUNT_BITS;
	localparam int BIAS_BITS   = SAMPLE_BITS + 8;
	localparam int DIFF_BITS   = BIAS_BITS + 1;
	localparam int DELTA_BITS  = 16;
	localparam int PROD_BITS   = DIFF_BITS + DELTA_BITS + 1;
	localparam int ACC_BITS    = 64;
	localparam int TIME_BITS   = 32;
	localparam int DB_BITS     = 23;
	localparam int CFG_BITS    = 32;
	localparam int DIV_BITS    = SUM_BITS + 8;

	localparam logic CFG_CALIB_WINDOW = 1'b0;
	localparam logic CFG_DEADBAND     = 1'b1;

	localparam logic [TIME_BITS-1:0] CALIB_WINDOW_RST = 32'd5000;
	localparam logic [DB_BITS-1:0]   DEADBAND_RST     = 23'd4198;

	typedef struct packed {
		logic                          new_sample;
		logic signed [SAMPLE_BITS-1:0] gyro_z;
		logic signed [SAMPLE_BITS-1:0] accel_z;
		logic [TIME_BITS-1:0]          time_ms;
		logic [DELTA_BITS-1:0]         delta_ms;
	} sample_t;

	typedef struct packed {
		logic signed [ACC_BITS-1:0] heading;
		logic signed [ACC_BITS-1:0] speed;
		logic                       is_calibrated;
	} result_t;

	typedef enum logic [1:0] {
		OP_ACCUM,
		OP_CALIB,
		OP_INTEG
	} op_t;

	typedef struct packed {
		op_t                           op;
		logic signed [SAMPLE_BITS-1:0] gyro;
		logic signed [SAMPLE_BITS-1:0] accel;
		logic [DELTA_BITS-1:0]         delta;
	} cmd_t;

	typedef enum logic [2:0] {
		BK_IDLE,
		BK_MUL,
		BK_ACC,
		BK_DIV_G,
		BK_DIV_A,
		BK_OUT
	} back_state_t;

	typedef struct packed {
		logic idle;
		logic dividing;
		logic div_busy;
		logic calibrated;
	} back_stat_t;

endpackage

// ===== design/gyro_bias_calibrate_integrate.sv =====
// top level of the gyro bias calibrate and integrate block
// depends on gbci_pkg, gbci_front, gbci_queue, gbci_back and the assertion macro header
//
// usage:
//  - input channel is queue-like: a transaction is taken at a clock edge with push high and
//    full low; the sample struct carries new_sample, gyro_z, accel_z, time_ms and delta_ms
//  - result channel is queue-like too: while empty is low the oldest result sits on result,
//    and pop with empty low takes it; every input transaction gives exactly one result
//  - config: cfg_we writes cfg_wdata into register cfg_addr (0 window, 1 deadband) at once;
//    write only while the block is idle
//  - the calibrate transaction runs the shared bit-serial divider twice, once per bias,
//    and skips it if nothing was summed; integrating passes through the multiply and
//    accumulate states before the result
//  - the back end state machine carries one command at a time and takes the next only
//    after the result of the last one is loaded
//  - a two-entry command queue lets the front keep taking transactions while the back works;
//    full rises once two commands wait
//  - a stalled receiver holds the result register; the back end then waits with its next
//    result and the command queue fills, after which full stays high
//  - reset clears sums, count, biases, accumulators, flags and queues; window reads 5000 ms
//    and deadband 4198
module gyro_bias_calibrate_integrate (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             push,
	output logic                             full,
	input  gbci_pkg::sample_t                sample,
	output logic                             empty,
	input  logic                             pop,
	output gbci_pkg::result_t                result,
	input  logic                             cfg_we,
	input  logic                             cfg_addr,
	input  logic [gbci_pkg::CFG_BITS-1:0]    cfg_wdata
);

	// configuration registers
	logic [gbci_pkg::TIME_BITS-1:0] calib_window_q;
	logic [gbci_pkg::DB_BITS-1:0]   deadband_q;

	// front to queue to back
	gbci_pkg::cmd_t       fr_cmd;
	logic                 fr_wr;
	logic                 fr_calibrated;
	gbci_pkg::cmd_t       q_head;
	logic                 q_rd;
	logic                 q_full;
	logic                 q_empty;
	gbci_pkg::back_stat_t bk_stat;

	// check terms
	logic                 back_quiet;
	logic                 calib_agree;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			calib_window_q <= gbci_pkg::CALIB_WINDOW_RST;
			deadband_q     <= gbci_pkg::DEADBAND_RST;
		end else if (cfg_we) begin
			case (cfg_addr)
				gbci_pkg::CFG_CALIB_WINDOW: calib_window_q <= cfg_wdata;
				gbci_pkg::CFG_DEADBAND:     deadband_q <= cfg_wdata[gbci_pkg::DB_BITS-1:0];
				default: begin
				end
			endcase
		end
	end

	// classification and held samples
	gbci_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.sample       (sample),
		.calib_window (calib_window_q),
		.q_full       (q_full),
		.cmd          (fr_cmd),
		.cmd_wr       (fr_wr),
		.calibrated   (fr_calibrated)
	);

	// decouples front and back
	gbci_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr      (fr_wr),
		.wr_data (fr_cmd),
		.rd      (q_rd),
		.rd_data (q_head),
		.full    (q_full),
		.empty   (q_empty)
	);

	// arithmetic and result register
	gbci_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_empty  (q_empty),
		.q_head   (q_head),
		.q_rd     (q_rd),
		.deadband (deadband_q),
		.pop      (pop),
		.empty    (empty),
		.result   (result),
		.stat     (bk_stat)
	);

	assign full = q_full;

	assign back_quiet  = q_empty && bk_stat.idle;
	assign calib_agree = (fr_calibrated == bk_stat.calibrated);

	// checks
	`include "gyro_bias_calibrate_integrate_assert.svh"

	// with nothing in flight the front's flag copy agrees with the back
	`GBCI_ASSERT_IMPLIES(a_calib_sync, back_quiet, calib_agree, "calibrated flags disagree")
	// divider only runs during a calibrate transaction
	`GBCI_ASSERT_IMPLIES(a_div_owner, bk_stat.div_busy, bk_stat.dividing, "stray divider run")
	// front never writes a full queue
	`GBCI_ASSERT_ALWAYS(a_no_overrun, !(fr_wr && q_full), "command queue written while full")

endmodule

// ===== design/gbci_queue.sv =====
// two-entry command queue between front and back
// depends on gbci_pkg
module gbci_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            wr,
	input  gbci_pkg::cmd_t  wr_data,
	input  logic            rd,
	output gbci_pkg::cmd_t  rd_data,
	output logic            full,
	output logic            empty
);

	gbci_pkg::cmd_t mem_q [2];
	logic           wr_ptr_q;
	logic           rd_ptr_q;
	logic [1:0]     count_q;

	assign full    = (count_q == 2'd2);
	assign empty   = (count_q == 2'd0);
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (wr && !full) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (wr && !full) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (rd && !empty) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			case ({wr && !full, rd && !empty})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// ===== design/gbci_div.sv =====
// restoring divider, one quotient bit per cycle
// depends on gbci_pkg
module gbci_div (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	input  logic [gbci_pkg::DIV_BITS-1:0]       dividend,
	input  logic [gbci_pkg::COUNT_BITS-1:0]     divisor,
	output logic                                busy,
	output logic                                done,
	output logic [gbci_pkg::DIV_BITS-1:0]       quot
);

	localparam int CNT_BITS = $clog2(gbci_pkg::DIV_BITS);

	logic                               busy_q;
	logic                               done_q;
	logic [CNT_BITS-1:0]                cnt_q;
	logic [gbci_pkg::COUNT_BITS-1:0]    rem_q;
	logic [gbci_pkg::COUNT_BITS-1:0]    dvs_q;
	logic [gbci_pkg::DIV_BITS-1:0]      dq_q;
	logic [gbci_pkg::COUNT_BITS:0]      trial;
	logic [gbci_pkg::COUNT_BITS:0]      diff;
	logic                               fits;

	// shift in the next dividend bit and try the subtract
	assign trial = {rem_q, dq_q[gbci_pkg::DIV_BITS-1]};
	assign diff  = trial - {1'b0, dvs_q};
	assign fits  = (trial >= {1'b0, dvs_q});

	assign busy = busy_q;
	assign done = done_q;
	assign quot = dq_q;

	always_ff @(posedge clk) begin
		if (start && !busy_q) begin
			rem_q <= '0;
			dvs_q <= divisor;
			dq_q  <= dividend;
		end else if (busy_q) begin
			rem_q <= fits ? diff[gbci_pkg::COUNT_BITS-1:0] : trial[gbci_pkg::COUNT_BITS-1:0];
			dq_q  <= {dq_q[gbci_pkg::DIV_BITS-2:0], fits};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == '0);
			if (start && !busy_q) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_BITS'(gbci_pkg::DIV_BITS - 1);
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
				end else begin
					cnt_q <= cnt_q - CNT_BITS'(1);
				end
			end
		end
	end

endmodule

// ===== design/gbci_front.sv =====
// front end: takes items, keeps held samples, classifies each item
// depends on gbci_pkg
module gbci_front (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             push,
	input  gbci_pkg::sample_t                sample,
	input  logic [gbci_pkg::TIME_BITS-1:0]   calib_window,
	input  logic                             q_full,
	output gbci_pkg::cmd_t                   cmd,
	output logic                             cmd_wr,
	output logic                             calibrated
);

	logic signed [gbci_pkg::SAMPLE_BITS-1:0] held_gyro_q;
	logic signed [gbci_pkg::SAMPLE_BITS-1:0] held_accel_q;
	logic                                    calib_q;

	assign cmd_wr     = push && !q_full;
	assign calibrated = calib_q;

	// build and classify the command; the own copy of the calibrated flag is set when the calibrate transaction is queued
	always_comb begin
		cmd.gyro  = sample.new_sample ? sample.gyro_z : held_gyro_q;
		cmd.accel = sample.new_sample ? sample.accel_z : held_accel_q;
		cmd.delta = sample.delta_ms;
		if (sample.time_ms < calib_window) begin
			cmd.op = gbci_pkg::OP_ACCUM;
		end else if (!calib_q) begin
			cmd.op = gbci_pkg::OP_CALIB;
		end else begin
			cmd.op = gbci_pkg::OP_INTEG;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_gyro_q  <= '0;
			held_accel_q <= '0;
			calib_q      <= 1'b0;
		end else if (cmd_wr) begin
			held_gyro_q  <= cmd.gyro;
			held_accel_q <= cmd.accel;
			if (cmd.op == gbci_pkg::OP_CALIB) begin
				calib_q <= 1'b1;
			end
		end
	end

endmodule

// ===== design/gbci_back.sv =====
// back end: sums, bias divide, deadband and saturating integration
// depends on gbci_pkg and gbci_div
module gbci_back (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           q_empty,
	input  gbci_pkg::cmd_t                 q_head,
	output logic                           q_rd,
	input  logic [gbci_pkg::DB_BITS-1:0]   deadband,
	input  logic                           pop,
	output logic                           empty,
	output gbci_pkg::result_t              result,
	output gbci_pkg::back_stat_t           stat
);

	localparam logic [gbci_pkg::COUNT_BITS-1:0] COUNT_MAX = '1;

	gbci_pkg::back_state_t state_q, state_d;

	logic signed [gbci_pkg::SUM_BITS-1:0]   gyro_sum_q, accel_sum_q;
	logic [gbci_pkg::COUNT_BITS-1:0]        count_q;
	logic signed [gbci_pkg::BIAS_BITS-1:0]  gyro_bias_q, accel_bias_q;
	logic                                   calib_q;
	logic signed [gbci_pkg::ACC_BITS-1:0]   heading_q, speed_q;
	logic signed [gbci_pkg::DIFF_BITS-1:0]  g_s1, a_s1;
	logic [gbci_pkg::DELTA_BITS-1:0]        dt_s1;
	logic signed [gbci_pkg::PROD_BITS-1:0]  pg_s2, pa_s2;
	logic                                   neg_q;
	gbci_pkg::result_t                      res_q;
	logic                                   res_valid_q;

	logic                                   start_any;
	logic                                   div_start;
	logic                                   div_busy;
	logic                                   div_done;
	logic [gbci_pkg::DIV_BITS-1:0]          div_dividend;
	logic [gbci_pkg::DIV_BITS-1:0]          div_quot;
	logic [gbci_pkg::SUM_BITS-1:0]          sum_mag;
	logic                                   sum_neg;
	logic signed [gbci_pkg::BIAS_BITS-1:0]  bias_val;
	logic signed [gbci_pkg::DIFF_BITS-1:0]  g_raw, a_raw, g_mag;
	logic                                   res_load;

	function automatic logic signed [gbci_pkg::ACC_BITS-1:0] sat_add(
		input logic signed [gbci_pkg::ACC_BITS-1:0]  acc,
		input logic signed [gbci_pkg::PROD_BITS-1:0] prod
	);
		logic signed [gbci_pkg::ACC_BITS:0] s;
		s = {acc[gbci_pkg::ACC_BITS-1], acc}
			+ {{(gbci_pkg::ACC_BITS + 1 - gbci_pkg::PROD_BITS){prod[gbci_pkg::PROD_BITS-1]}}, prod};
		if (s[gbci_pkg::ACC_BITS] != s[gbci_pkg::ACC_BITS-1]) begin
			sat_add = s[gbci_pkg::ACC_BITS]
				? {1'b1, {(gbci_pkg::ACC_BITS-1){1'b0}}}
				: {1'b0, {(gbci_pkg::ACC_BITS-1){1'b1}}};
		end else begin
			sat_add = s[gbci_pkg::ACC_BITS-1:0];
		end
	endfunction

	gbci_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (count_q),
		.busy     (div_busy),
		.done     (div_done),
		.quot     (div_quot)
	);

	// one divider, gyro mean first, then accel mean
	always_comb begin
		sum_neg      = (state_q == gbci_pkg::BK_IDLE) ? gyro_sum_q[gbci_pkg::SUM_BITS-1]
		                                              : accel_sum_q[gbci_pkg::SUM_BITS-1];
		sum_mag      = (state_q == gbci_pkg::BK_IDLE)
			? (sum_neg ? gbci_pkg::SUM_BITS'(-gyro_sum_q) : gbci_pkg::SUM_BITS'(gyro_sum_q))
			: (sum_neg ? gbci_pkg::SUM_BITS'(-accel_sum_q) : gbci_pkg::SUM_BITS'(accel_sum_q));
		div_dividend = {sum_mag, 8'd0};
		bias_val     = neg_q ? -$signed(div_quot[gbci_pkg::BIAS_BITS-1:0])
		                     : $signed(div_quot[gbci_pkg::BIAS_BITS-1:0]);
	end

	// bias removal and deadband on the queue head
	always_comb begin
		g_raw = $signed({q_head.gyro[gbci_pkg::SAMPLE_BITS-1], q_head.gyro, 8'd0})
			- $signed({gyro_bias_q[gbci_pkg::BIAS_BITS-1], gyro_bias_q});
		a_raw = $signed({q_head.accel[gbci_pkg::SAMPLE_BITS-1], q_head.accel, 8'd0})
			- $signed({accel_bias_q[gbci_pkg::BIAS_BITS-1], accel_bias_q});
		g_mag = g_raw[gbci_pkg::DIFF_BITS-1] ? -g_raw : g_raw;
	end

	always_comb begin
		state_d   = state_q;
		q_rd      = 1'b0;
		start_any = 1'b0;
		res_load  = 1'b0;
		case (state_q)
			gbci_pkg::BK_IDLE: begin
				if (!q_empty) begin
					q_rd = 1'b1;
					case (q_head.op)
						gbci_pkg::OP_ACCUM: state_d = gbci_pkg::BK_OUT;
						gbci_pkg::OP_CALIB: begin
							if (count_q == '0) begin
								state_d = gbci_pkg::BK_OUT;
							end else begin
								start_any = 1'b1;
								state_d   = gbci_pkg::BK_DIV_G;
							end
						end
						gbci_pkg::OP_INTEG: state_d = gbci_pkg::BK_MUL;
						default:            state_d = gbci_pkg::BK_OUT;
					endcase
				end
			end
			gbci_pkg::BK_MUL: state_d = gbci_pkg::BK_ACC;
			gbci_pkg::BK_ACC: state_d = gbci_pkg::BK_OUT;
			gbci_pkg::BK_DIV_G: begin
				if (div_done) begin
					start_any = 1'b1;
					state_d   = gbci_pkg::BK_DIV_A;
				end
			end
			gbci_pkg::BK_DIV_A: begin
				if (div_done) begin
					state_d = gbci_pkg::BK_OUT;
				end
			end
			gbci_pkg::BK_OUT: begin
				if (!res_valid_q || pop) begin
					res_load = 1'b1;
					state_d  = gbci_pkg::BK_IDLE;
				end
			end
			default: state_d = gbci_pkg::BK_IDLE;
		endcase
	end

	assign div_start = start_any;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= gbci_pkg::BK_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gyro_sum_q   <= '0;
			accel_sum_q  <= '0;
			count_q      <= '0;
			gyro_bias_q  <= '0;
			accel_bias_q <= '0;
			calib_q      <= 1'b0;
			heading_q    <= '0;
			speed_q      <= '0;
			neg_q        <= 1'b0;
			res_valid_q  <= 1'b0;
		end else begin
			if (start_any) begin
				neg_q <= sum_neg;
			end
			if (q_rd) begin
				case (q_head.op)
					gbci_pkg::OP_ACCUM: begin
						if (count_q != COUNT_MAX) begin
							gyro_sum_q  <= gyro_sum_q + gbci_pkg::SUM_BITS'(q_head.gyro);
							accel_sum_q <= accel_sum_q + gbci_pkg::SUM_BITS'(q_head.accel);
							count_q     <= count_q + gbci_pkg::COUNT_BITS'(1);
						end
					end
					gbci_pkg::OP_CALIB: begin
						// empty window leaves both biases at zero
						if (count_q == '0) begin
							calib_q <= 1'b1;
						end
					end
					default: begin
					end
				endcase
			end
			if (state_q == gbci_pkg::BK_DIV_G && div_done) begin
				gyro_bias_q <= bias_val;
			end
			if (state_q == gbci_pkg::BK_DIV_A && div_done) begin
				accel_bias_q <= bias_val;
				calib_q      <= 1'b1;
			end
			if (state_q == gbci_pkg::BK_ACC) begin
				heading_q <= sat_add(heading_q, pg_s2);
				speed_q   <= sat_add(speed_q, pa_s2);
			end
			if (res_load) begin
				res_valid_q <= 1'b1;
			end else if (pop) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	// integrate datapath stages
	always_ff @(posedge clk) begin
		if (q_rd && q_head.op == gbci_pkg::OP_INTEG) begin
			g_s1  <= (g_mag < $signed({2'b00, deadband})) ? '0 : g_raw;
			a_s1  <= a_raw;
			dt_s1 <= q_head.delta;
		end
		if (state_q == gbci_pkg::BK_MUL) begin
			pg_s2 <= gbci_pkg::PROD_BITS'(g_s1) * gbci_pkg::PROD_BITS'($signed({1'b0, dt_s1}));
			pa_s2 <= gbci_pkg::PROD_BITS'(a_s1) * gbci_pkg::PROD_BITS'($signed({1'b0, dt_s1}));
		end
		if (res_load) begin
			res_q.heading       <= heading_q;
			res_q.speed         <= speed_q;
			res_q.is_calibrated <= calib_q;
		end
	end

	assign empty  = !res_valid_q;
	assign result = res_q;

	assign stat.idle       = (state_q == gbci_pkg::BK_IDLE);
	assign stat.dividing   = (state_q == gbci_pkg::BK_DIV_G) || (state_q == gbci_pkg::BK_DIV_A);
	assign stat.div_busy   = div_busy;
	assign stat.calibrated = calib_q;

endmodule
